// ===== sv/rsl_pkg.sv =====
package rsl_pkg;

    // defaults for the top-level parameters
    localparam int ENTRIES_DEF   = 128;
    localparam int TAG_BYTES_DEF = 32;

    // fixed field widths
    localparam int WORD_W   = 64;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;

    // slots reachable by a write request
    localparam int SLOT_SPAN = 1 << SLOT_W;

    // request codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // bit 31 of the first tag word marks an id
    localparam int ID_FLAG_BIT = 31;
    localparam int ID_W        = 32;

    // controller to datapath
    typedef struct packed {
        logic wr_en;
        logic scan_start;
        logic step;
        logic out_load;
    } t_rsl_cmd;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic out_full;
    } t_rsl_sts;

endpackage

// ===== sv/rsl_ctrl.sv =====
module rsl_ctrl
    import rsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_cmd,
    output logic     o_in_ready,
    input  t_rsl_sts i_sts,
    output t_rsl_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state          = r_state;
        o_cmd.wr_en      = 1'b0;
        o_cmd.scan_start = 1'b0;
        o_cmd.step       = 1'b0;
        o_cmd.out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // stop issuing reads once the compare stage has its answer
                o_cmd.step = !i_sts.done;
                if (i_sts.done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/rsl_dpath.sv =====
module rsl_dpath
    import rsl_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int TAG_BYTES = TAG_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_rsl_cmd            i_cmd,
    output t_rsl_sts            o_sts,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_in_use,
    input  logic                i_key_is_id,
    input  logic [WORD_W-1:0]   i_text_w0,
    input  logic [WORD_W-1:0]   i_text_w1,
    input  logic [WORD_W-1:0]   i_text_w2,
    input  logic [WORD_W-1:0]   i_text_w3,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_found_slot
);

    localparam int TAG_W   = TAG_BYTES * 8;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int WR_ENT  = (ENTRIES < SLOT_SPAN) ? ENTRIES : SLOT_SPAN;
    localparam int MEM_AW  = (WR_ENT > 1) ? $clog2(WR_ENT) : 1;

    // tag store, one row per entry that a write can reach
    logic [TAG_W-1:0]  mem [WR_ENT];
    logic [WR_ENT-1:0] r_use;

    logic [TAG_W-1:0]  r_key;
    logic              r_key_is_id;

    logic [IDX_W-1:0]  r_addr;
    logic              r_rd_valid;
    logic              r_rd_last;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [TAG_W-1:0]  r_rd_text;
    logic              r_rd_use;

    logic              r_have_free;
    logic [IDX_W-1:0]  r_free_idx;

    logic [STATUS_W-1:0] r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;

    logic [4*WORD_W-1:0] w_full_tag;
    logic [TAG_W-1:0]    w_tag;
    logic                w_wr_ok;
    logic                w_rd_ok;
    logic [TAG_BYTES-1:0] w_eq;
    logic [TAG_BYTES-1:0] w_term;
    logic [TAG_BYTES-1:0] w_bad;
    logic                w_ent_is_id;
    logic                w_id_hit;
    logic                w_name_hit;
    logic                w_hit;
    logic                w_done;
    logic                w_free_now;

    assign w_full_tag = {i_text_w3, i_text_w2, i_text_w1, i_text_w0};
    assign w_tag      = w_full_tag[TAG_W-1:0];
    assign w_wr_ok    = ({1'b0, i_slot} < (SLOT_W+1)'(WR_ENT));
    assign w_rd_ok    = ({1'b0, r_addr} < (IDX_W+1)'(WR_ENT));

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_wr_ok) begin
            mem[i_slot[MEM_AW-1:0]] <= w_tag;
        end
        if (i_cmd.step) begin
            r_rd_text <= mem[r_addr[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use <= '0;
        end else if (i_cmd.wr_en && w_wr_ok) begin
            r_use[i_slot[MEM_AW-1:0]] <= i_in_use;
        end
    end

    // compare stage
    always_comb begin
        for (int j = 0; j < TAG_BYTES; j++) begin
            w_eq[j]   = (r_rd_text[j*8 +: 8] == r_key[j*8 +: 8]);
            w_term[j] = w_eq[j] && (r_rd_text[j*8 +: 8] == 8'h00);
        end
        // a mismatch counts only if no equal NUL came before it
        for (int j = 0; j < TAG_BYTES; j++) begin
            w_bad[j] = !w_eq[j] &&
                       !(|(w_term & ((TAG_BYTES)'(1) << j) - (TAG_BYTES)'(1)));
        end
    end

    assign w_ent_is_id = r_rd_text[ID_FLAG_BIT];
    assign w_id_hit    = w_ent_is_id && r_key[ID_FLAG_BIT] &&
                         (r_rd_text[ID_W-1:0] == r_key[ID_W-1:0]);
    assign w_name_hit  = !w_ent_is_id && !(|w_bad);
    assign w_hit       = r_rd_use && (r_key_is_id ? w_id_hit : w_name_hit);
    assign w_free_now  = !r_rd_use;
    assign w_done      = r_rd_valid && (w_hit || r_rd_last);

    assign o_sts.done     = w_done;
    assign o_sts.out_full = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_key       <= w_tag;
            r_key_is_id <= i_key_is_id;
        end
        if (i_cmd.step) begin
            r_rd_idx  <= r_addr;
            r_rd_last <= (r_addr == IDX_W'(ENTRIES - 1));
            r_rd_use  <= w_rd_ok ? r_use[r_addr[MEM_AW-1:0]] : 1'b0;
        end
        if (r_rd_valid && w_free_now) begin
            r_free_idx <= r_rd_idx;
        end
        if (w_done) begin
            if (w_hit) begin
                r_res_status <= ST_HIT;
                r_res_slot   <= SLOT_W'(r_rd_idx);
            end else if (w_free_now) begin
                r_res_status <= ST_FREE;
                r_res_slot   <= SLOT_W'(r_rd_idx);
            end else if (r_have_free) begin
                r_res_status <= ST_FREE;
                r_res_slot   <= SLOT_W'(r_free_idx);
            end else begin
                r_res_status <= ST_FULL;
                r_res_slot   <= '0;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_rd_valid  <= 1'b0;
            r_have_free <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.step;
            if (i_cmd.scan_start) begin
                r_addr      <= '0;
                r_have_free <= 1'b0;
            end else begin
                if (i_cmd.step) begin
                    r_addr <= r_addr + IDX_W'(1);
                end
                if (r_rd_valid && w_free_now) begin
                    r_have_free <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_found_slot = r_out_slot;

endmodule

// ===== sv/resource_slot_lookup_unit.sv =====
// channel   handshake                       payload
// -------   -----------------------------   ---------------------------------------------
// request   i_in_valid / o_in_ready          i_cmd i_slot i_in_use i_key_is_id i_text_w0..3
// result    o_out_valid / i_out_ready       o_status o_found_slot
//
// a write request is taken while the unit is idle and gives no result
// a lookup scans one entry per cycle through the tag store read port; the scan
// stops at the first hit or after the last entry; no new request is taken until
// the result is registered
// synchronous active-low reset clears the in-use marks; tag rows are not cleared
// a stalled result sits in the output register while new requests are taken
module resource_slot_lookup_unit
    import rsl_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int TAG_BYTES = TAG_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_cmd,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_in_use,
    input  logic                i_key_is_id,
    input  logic [WORD_W-1:0]   i_text_w0,
    input  logic [WORD_W-1:0]   i_text_w1,
    input  logic [WORD_W-1:0]   i_text_w2,
    input  logic [WORD_W-1:0]   i_text_w3,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_found_slot
);

    // command and status between the controller and the datapath
    t_rsl_cmd w_cmd;
    t_rsl_sts w_sts;

    // controller: idle, scan, then hold until the output register is free
    rsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: tag store, in-use marks, compare stage, result registers
    rsl_dpath #(
        .ENTRIES   (ENTRIES),
        .TAG_BYTES (TAG_BYTES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_slot       (i_slot),
        .i_in_use     (i_in_use),
        .i_key_is_id  (i_key_is_id),
        .i_text_w0    (i_text_w0),
        .i_text_w1    (i_text_w1),
        .i_text_w2    (i_text_w2),
        .i_text_w3    (i_text_w3),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_found_slot (o_found_slot)
    );

endmodule

// ===== tb/resource_slot_lookup_unit_tb.sv =====
module resource_slot_lookup_unit_tb;
    import rsl_pkg::*;

    localparam int ENTRIES      = ENTRIES_DEF;
    localparam int TAG_BYTES    = TAG_BYTES_DEF;
    localparam int POOL_SIZE    = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = ENTRIES + 64;

    // four little-endian tag words, byte b lives in word b/8
    typedef logic [3:0][WORD_W-1:0] t_text;

    typedef struct packed {
        logic              cmd;
        logic [SLOT_W-1:0] slot;
        logic              in_use;
        logic              key_is_id;
        t_text             text;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } t_answer;

    // a tag the random part keeps coming back to, so lookups really hit
    typedef struct {
        bit    is_id;
        int    len;
        t_text text;
    } t_tag;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_HELD} t_rdy_mode;

    // dut ports, all inputs known from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_cmd       = CMD_LOOKUP;
    logic [SLOT_W-1:0]   i_slot      = '0;
    logic                i_in_use    = 1'b0;
    logic                i_key_is_id = 1'b0;
    logic [WORD_W-1:0]   i_text_w0   = '0;
    logic [WORD_W-1:0]   i_text_w1   = '0;
    logic [WORD_W-1:0]   i_text_w2   = '0;
    logic [WORD_W-1:0]   i_text_w3   = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_found_slot;

    // shadow copy of the slot table
    logic  tbl_used [ENTRIES];
    t_text tbl_text [ENTRIES];

    t_request  requests_to_send[$];
    t_answer   lookup_answers[$];
    t_tag      tag_pool[POOL_SIZE];
    t_request  on_bus;
    t_answer   want;
    int        burst_left = 1;
    int        gap_left   = 0;
    t_rdy_mode rdy_mode   = RDY_ALWAYS;
    int        rdy_left   = 0;
    int        mismatches = 0;
    int        cycle_cnt  = 0;

    resource_slot_lookup_unit #(
        .ENTRIES   (ENTRIES),
        .TAG_BYTES (TAG_BYTES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_slot       (i_slot),
        .i_in_use     (i_in_use),
        .i_key_is_id  (i_key_is_id),
        .i_text_w0    (i_text_w0),
        .i_text_w1    (i_text_w1),
        .i_text_w2    (i_text_w2),
        .i_text_w3    (i_text_w3),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_found_slot (o_found_slot)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // names agree up to and including the first nul, or over all tag bytes
    function automatic bit same_name(input t_text a, input t_text b);
        logic [7:0] x;
        logic [7:0] y;
        for (int i = 0; i < TAG_BYTES; i++) begin
            x = a[i >> 3][(i & 7) * 8 +: 8];
            y = b[i >> 3][(i & 7) * 8 +: 8];
            if (x != y) return 1'b0;
            if (x == 8'h00) return 1'b1;
        end
        return 1'b1;
    endfunction

    // first in-use match in index order, else highest unused slot, else full
    function automatic t_answer scan_table(input t_request r);
        t_answer     a;
        logic [31:0] kid;
        logic [31:0] eid;
        bit          hit;
        bit          got_free;
        int          free_at;
        kid      = r.text[0][ID_W-1:0];
        got_free = 1'b0;
        free_at  = 0;
        for (int e = 0; e < ENTRIES; e++) begin
            if (tbl_used[e]) begin
                eid = tbl_text[e][0][ID_W-1:0];
                if (r.key_is_id)
                    hit = eid[ID_FLAG_BIT] && kid[ID_FLAG_BIT] && (kid == eid);
                else
                    hit = !eid[ID_FLAG_BIT] && same_name(tbl_text[e], r.text);
                if (hit) begin
                    a.status = ST_HIT;
                    a.slot   = SLOT_W'(e);
                    return a;
                end
            end else begin
                got_free = 1'b1;
                free_at  = e;
            end
        end
        if (got_free) begin
            a.status = ST_FREE;
            a.slot   = SLOT_W'(free_at);
        end else begin
            a.status = ST_FULL;
            a.slot   = '0;
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------

    function automatic t_text name_text(input string s);
        t_text t;
        t = '0;
        for (int i = 0; i < s.len() && i < TAG_BYTES; i++)
            t[i >> 3][(i & 7) * 8 +: 8] = s[i];
        return t;
    endfunction

    function automatic t_text noise_text();
        t_text t;
        for (int w = 0; w < 4; w++)
            t[w] = {$urandom, $urandom};
        return t;
    endfunction

    // fill the don't-care bytes of a pool tag with junk; an entry must keep
    // byte 3 below 0x80 or it would turn into an id
    function automatic t_text dressed(input t_tag g, input bit as_entry);
        t_text      t;
        logic [7:0] b;
        t = g.text;
        if (g.is_id) begin
            t[0][WORD_W-1:ID_W] = $urandom;
            for (int w = 1; w < 4; w++)
                t[w] = {$urandom, $urandom};
        end else begin
            for (int i = g.len + 1; i < TAG_BYTES; i++) begin
                b = 8'($urandom);
                if (as_entry && i == 3) b[7] = 1'b0;
                t[i >> 3][(i & 7) * 8 +: 8] = b;
            end
        end
        return t;
    endfunction

    // unused fields get random values, the dut has to ignore them
    task automatic push_write(input int slot, input bit used, input t_text t);
        t_request r;
        r.cmd       = CMD_WRITE;
        r.slot      = SLOT_W'(slot);
        r.in_use    = used;
        r.key_is_id = 1'($urandom);
        r.text      = t;
        requests_to_send.push_back(r);
    endtask

    task automatic push_lookup(input bit is_id, input t_text t);
        t_request r;
        r.cmd       = CMD_LOOKUP;
        r.slot      = SLOT_W'($urandom);
        r.in_use    = 1'($urandom);
        r.key_is_id = is_id;
        r.text      = t;
        requests_to_send.push_back(r);
    endtask

    task automatic build_pool();
        logic [7:0] b;
        for (int p = 0; p < POOL_SIZE; p++) begin
            tag_pool[p].text = '0;
            if (p < 10) begin
                tag_pool[p].is_id = 1'b0;
                tag_pool[p].len   = (p == 0) ? 0 : (p == 1) ? TAG_BYTES :
                                    (p == 2) ? TAG_BYTES - 1 : $urandom_range(1, 12);
                for (int i = 0; i < tag_pool[p].len; i++) begin
                    b = (i == 3) ? 8'($urandom_range(1, 127)) : 8'($urandom_range(1, 255));
                    tag_pool[p].text[i >> 3][(i & 7) * 8 +: 8] = b;
                end
            end else begin
                tag_pool[p].is_id = 1'b1;
                tag_pool[p].len   = 0;
                tag_pool[p].text[0][ID_W-1:0] = $urandom;
                tag_pool[p].text[0][ID_FLAG_BIT] = 1'b1;
            end
        end
    endtask

    // mixed traffic: writes of pool tags and junk, lookups that hit, that
    // just miss, that use the wrong key kind, and pure noise
    task automatic rand_mix(input int n);
        int    roll;
        int    at;
        t_tag  g;
        t_text t;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            g    = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (roll < 45) begin
                t = ($urandom_range(0, 9) < 7) ? dressed(g, 1'b1) : noise_text();
                push_write($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                : $urandom_range(0, ENTRIES - 1),
                           $urandom_range(0, 9) != 0, t);
            end else if (roll < 72) begin
                push_lookup(g.is_id, dressed(g, 1'b0));
            end else if (roll < 78) begin
                push_lookup(!g.is_id, dressed(g, 1'b0));
            end else if (roll < 90) begin
                // near miss: one id bit or one name byte off, may shorten or lengthen the name
                t = dressed(g, 1'b0);
                if (g.is_id) begin
                    t[0] = t[0] ^ (64'd1 << $urandom_range(0, ID_FLAG_BIT - 1));
                end else begin
                    at = $urandom_range(0, (g.len < TAG_BYTES) ? g.len : TAG_BYTES - 1);
                    t[at >> 3][(at & 7) * 8 +: 8] =
                        t[at >> 3][(at & 7) * 8 +: 8] ^ 8'($urandom_range(1, 255));
                end
                push_lookup(g.is_id, t);
            end else begin
                push_lookup(1'($urandom), noise_text());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            for (int e = 0; e < ENTRIES; e++)
                tbl_used[e] = 1'b0;
        end else begin
            // request taken at this edge: update the shadow table or predict
            if (i_in_valid && o_in_ready) begin
                if (on_bus.cmd == CMD_WRITE) begin
                    if (int'(on_bus.slot) < ENTRIES) begin
                        tbl_used[on_bus.slot] = on_bus.in_use;
                        tbl_text[on_bus.slot] = on_bus.text;
                    end
                end else begin
                    lookup_answers.push_back(scan_table(on_bus));
                end
            end
            // the payload only moves once the current request is gone
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0 || requests_to_send.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    on_bus = requests_to_send.pop_front();
                    i_in_valid  <= 1'b1;
                    i_cmd       <= on_bus.cmd;
                    i_slot      <= on_bus.slot;
                    i_in_use    <= on_bus.in_use;
                    i_key_is_id <= on_bus.key_is_id;
                    i_text_w0   <= on_bus.text[0];
                    i_text_w1   <= on_bus.text[1];
                    i_text_w2   <= on_bus.text[2];
                    i_text_w3   <= on_bus.text[3];
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: compare against the oldest prediction, stall on a
    // mix of always-ready, coin-flip and held-off stretches
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (lookup_answers.size() == 0) begin
                    $error("result with no lookup pending: status %0d found_slot %0d",
                           o_status, o_found_slot);
                    mismatches++;
                end else begin
                    want = lookup_answers.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_found_slot !== want.slot) begin
                        $error("found_slot: expected %0d, actual %0d",
                               want.slot, o_found_slot);
                        mismatches++;
                    end
                end
            end
            if (rdy_left == 0) begin
                rdy_mode = t_rdy_mode'($urandom_range(0, 2));
                rdy_left = (rdy_mode == RDY_HELD) ? $urandom_range(1, 200)
                                                  : $urandom_range(1, 400);
            end else begin
                rdy_left--;
            end
            case (rdy_mode)
                RDY_ALWAYS: i_out_ready <= 1'b1;
                RDY_RANDOM: i_out_ready <= 1'($urandom);
                default:    i_out_ready <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        t_text t;
        t_tag  g;
        int    s;
        bit    timed_out;

        build_pool();

        // empty table after reset, name and id keys: highest slot is free
        push_lookup(1'b0, '0);
        t = '0;
        t[0][ID_FLAG_BIT] = 1'b1;
        push_lookup(1'b1, t);
        push_write(ENTRIES - 1, 1'b1, name_text("a"));
        push_lookup(1'b0, name_text("a"));

        // name whose first word looks like an id with the flag clear:
        // an id key with the same word must not match it
        t = '0;
        t[0] = 64'h0000_0000_1234_5678;
        push_write(0, 1'b1, t);
        push_lookup(1'b1, t);
        push_lookup(1'b0, t);

        // id entry: upper key bits are don't-care, a name key never hits it
        t = '1;
        t[0][ID_W-1:0] = 32'hDEAD_BEEF;
        push_write(5, 1'b1, t);
        t[0][WORD_W-1:ID_W] = '0;
        t[3] = '0;
        push_lookup(1'b1, t);
        push_lookup(1'b0, t);

        // same id lower down: first match in index order wins
        push_write(3, 1'b1, t);
        push_lookup(1'b1, t);

        // full-length name without a nul, then one differing last byte
        t = '1;
        t[0][31:24] = 8'h7F;
        push_write(1, 1'b1, t);
        push_lookup(1'b0, t);
        t[3][63:56] = 8'hFE;
        push_lookup(1'b0, t);

        // bytes past the nul are ignored, a longer key misses
        t = name_text("abc");
        t[0][63:32] = 32'h5A5A_5A5A;
        t[2] = 64'h0123_4567_89AB_CDEF;
        push_write(2, 1'b1, t);
        t = name_text("abc");
        t[0][63:32] = '1;
        t[1] = '1;
        t[3] = '1;
        push_lookup(1'b0, t);
        push_lookup(1'b0, name_text("abcd"));

        // name key with byte 3 set to 0x80 behind its nul still matches
        push_write(6, 1'b1, name_text("ab"));
        t = name_text("ab");
        t[0][31:24] = 8'h80;
        push_lookup(1'b0, t);

        // empty name, all-ones id, then release the top slot again
        push_write(4, 1'b1, '0);
        push_lookup(1'b0, '0);
        push_write(7, 1'b1, '1);
        push_lookup(1'b1, '1);
        push_write(ENTRIES - 1, 1'b0, name_text("a"));
        push_lookup(1'b0, name_text("a"));

        rand_mix(150);

        // every slot in use: misses report a full table
        for (int e = 0; e < ENTRIES; e++) begin
            g = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
            push_write(e, 1'b1, (e % 3 == 0) ? dressed(g, 1'b1) : noise_text());
        end
        for (int k = 0; k < 4; k++) begin
            g = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
            push_lookup(g.is_id, dressed(g, 1'b0));
            push_lookup(1'($urandom), noise_text());
        end

        // free a few scattered slots one by one
        for (int k = 0; k < 5; k++) begin
            s = $urandom_range(0, ENTRIES - 1);
            push_write(s, 1'b0, noise_text());
            push_lookup(1'($urandom), noise_text());
        end

        rand_mix(130);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to go out and every lookup to be answered
        while (!(requests_to_send.size() == 0 && !i_in_valid && lookup_answers.size() == 0)
               && cycle_cnt < CYCLE_LIMIT)
            @(negedge i_clk);
        timed_out = (cycle_cnt >= CYCLE_LIMIT);

        // let a trailing write or a stray result surface
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (!timed_out && mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
